// ===== sv/tbeq_pkg.sv =====
// ----------------------------------------------------------------------------
// tbeq_pkg
// Types and constants shared by the touch and button event qualifier.
// ----------------------------------------------------------------------------
package tbeq_pkg;

    localparam int MASK_W   = 9;
    localparam int RAW_W    = 8;
    localparam int POINT_W  = 7;
    localparam int IDLE_W   = 12;
    localparam int LOCK_W   = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;
    localparam int MAX_RESULTS = 3;
    localparam int S_DATA_W = 32;
    localparam int M_DATA_W = 16;
    localparam int M_USER_W = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_TOUCH_ENABLED     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SENSOR_LOCK_LIMIT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IDLE_LIMIT        = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MOVE_THRESHOLD    = 2'd3;

    localparam logic [LOCK_W-1:0] RST_SENSOR_LOCK_LIMIT = 8'd80;
    localparam logic [IDLE_W-1:0] RST_IDLE_LIMIT        = 12'd1500;
    localparam logic [POINT_W-1:0] RST_MOVE_THRESHOLD   = 7'd3;

    typedef enum logic [2:0] {
        EV_BUTTON  = 3'd0,
        EV_DOWN    = 3'd1,
        EV_MOVE    = 3'd2,
        EV_UP      = 3'd3,
        EV_TIMEOUT = 3'd4
    } event_kind_t;

    typedef struct packed {
        logic               touch_enabled;
        logic [LOCK_W-1:0]  sensor_lock_limit;
        logic [IDLE_W-1:0]  idle_limit;
        logic [POINT_W-1:0] move_threshold;
    } cfg_t;

    typedef struct packed {
        logic               button_pressed;
        logic               read_ok;
        logic [MASK_W-1:0]  sensor_mask;
        logic [RAW_W-1:0]   raw_x;
        logic [RAW_W-1:0]   raw_y;
    } tick_t;

    typedef struct packed {
        event_kind_t        kind;
        logic               controller_reset;
        logic [POINT_W-1:0] point_x;
        logic [POINT_W-1:0] point_y;
    } result_t;

    typedef struct packed {
        result_t [MAX_RESULTS-1:0] items;
        logic [1:0]                count;
    } bundle_t;

endpackage

// ===== sv/tbeq_core.sv =====
// ----------------------------------------------------------------------------
// tbeq_core
// Qualifier state and the single-pass evaluation of one poll tick.
// ----------------------------------------------------------------------------
module tbeq_core #(
    parameter int SENSOR_COUNT = 9
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  tbeq_pkg::cfg_t   cfg,
    input  tbeq_pkg::tick_t  tick,
    input  logic             step,
    output tbeq_pkg::bundle_t bundle
);
    import tbeq_pkg::*;

    logic [LOCK_W-1:0]  sensor_cnt_reg  [SENSOR_COUNT];
    logic [LOCK_W-1:0]  sensor_cnt_next [SENSOR_COUNT];
    logic               first_touch_reg, first_touch_next;
    logic               button_prev_reg;
    logic               touch_prev_reg, touch_prev_next;
    logic [POINT_W-1:0] last_x_reg, last_x_next;
    logic [POINT_W-1:0] last_y_reg, last_y_next;
    logic [IDLE_W-1:0]  idle_count_reg, idle_count_next;

    logic [SENSOR_COUNT+MASK_W-1:0] mask_ext;
    assign mask_ext = {{SENSOR_COUNT{1'b0}}, tick.sensor_mask};

    always_comb begin
        logic [LOCK_W-1:0]  cnt_upd [SENSOR_COUNT];
        logic               touch_path;
        logic               trip;
        logic               valid;
        logic               moved;
        logic [POINT_W-1:0] px;
        logic [POINT_W-1:0] py;
        logic [POINT_W-1:0] dx;
        logic [POINT_W-1:0] dy;
        logic [IDLE_W-1:0]  idle_base;
        logic               fire;
        logic               touch_evt;
        result_t            touch_item;
        result_t            zero_item;
        logic [1:0]         n;

        touch_path = cfg.touch_enabled && tick.read_ok;
        trip = 1'b0;
        for (int i = 0; i < SENSOR_COUNT; i++) begin
            if (mask_ext[i]) begin
                cnt_upd[i] = sensor_cnt_reg[i] + 8'd1;
                if (cnt_upd[i] >= cfg.sensor_lock_limit) begin
                    trip = 1'b1;
                end
            end else begin
                cnt_upd[i] = '0;
            end
        end
        trip = trip && touch_path;

        px = ~tick.raw_x[POINT_W-1:0];
        py = ~tick.raw_y[POINT_W-1:0];
        valid = touch_path && !trip && (tick.sensor_mask != '0) && !first_touch_reg
            && !tick.raw_x[RAW_W-1] && !tick.raw_y[RAW_W-1];
        dx = (last_x_reg > px) ? last_x_reg - px : px - last_x_reg;
        dy = (last_y_reg > py) ? last_y_reg - py : py - last_y_reg;
        moved = (dx > cfg.move_threshold) || (dy > cfg.move_threshold);

        // touch slot
        touch_evt  = 1'b0;
        touch_item = '{kind: EV_UP, controller_reset: 1'b0,
                       point_x: last_x_reg, point_y: last_y_reg};
        if (trip) begin
            touch_evt = 1'b1;
            touch_item.controller_reset = 1'b1;
        end else if (valid) begin
            if (!touch_prev_reg || moved) begin
                touch_evt = 1'b1;
                touch_item.kind = touch_prev_reg ? EV_MOVE : EV_DOWN;
                touch_item.point_x = px;
                touch_item.point_y = py;
            end
        end else if (touch_prev_reg) begin
            touch_evt = 1'b1;
        end

        // idle timeout
        idle_base = (tick.button_pressed || valid) ? '0 : idle_count_reg;
        fire = 1'b0;
        if (idle_base < cfg.idle_limit) begin
            idle_count_next = idle_base + 12'd1;
            fire = (idle_count_next == cfg.idle_limit);
        end else begin
            idle_count_next = idle_base;
        end

        // compact results in order button, touch, timeout
        zero_item = '{kind: EV_BUTTON, controller_reset: 1'b0, point_x: '0, point_y: '0};
        bundle.items = '{default: zero_item};
        n = 2'd0;
        if (tick.button_pressed && !button_prev_reg) begin
            bundle.items[n] = zero_item;
            n = n + 2'd1;
        end
        if (touch_evt) begin
            bundle.items[n] = touch_item;
            n = n + 2'd1;
        end
        if (fire) begin
            bundle.items[n] = '{kind: EV_TIMEOUT, controller_reset: 1'b0,
                                point_x: '0, point_y: '0};
            n = n + 2'd1;
        end
        bundle.count = n;

        // next state
        for (int i = 0; i < SENSOR_COUNT; i++) begin
            if (touch_path) begin
                sensor_cnt_next[i] = trip ? '0 : cnt_upd[i];
            end else begin
                sensor_cnt_next[i] = sensor_cnt_reg[i];
            end
        end
        first_touch_next = first_touch_reg;
        if (touch_path) begin
            if (trip || tick.sensor_mask == '0) begin
                first_touch_next = 1'b1;
            end else begin
                first_touch_next = 1'b0;
            end
        end
        touch_prev_next = valid;
        last_x_next = last_x_reg;
        last_y_next = last_y_reg;
        if (valid && (!touch_prev_reg || moved)) begin
            last_x_next = px;
            last_y_next = py;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < SENSOR_COUNT; i++) begin
                sensor_cnt_reg[i] <= '0;
            end
            first_touch_reg <= 1'b1;
            button_prev_reg <= 1'b0;
            touch_prev_reg  <= 1'b0;
            last_x_reg      <= '0;
            last_y_reg      <= '0;
            idle_count_reg  <= '0;
        end else if (step) begin
            for (int i = 0; i < SENSOR_COUNT; i++) begin
                sensor_cnt_reg[i] <= sensor_cnt_next[i];
            end
            first_touch_reg <= first_touch_next;
            button_prev_reg <= tick.button_pressed;
            touch_prev_reg  <= touch_prev_next;
            last_x_reg      <= last_x_next;
            last_y_reg      <= last_y_next;
            idle_count_reg  <= idle_count_next;
        end
    end

endmodule

// ===== sv/touch_button_event_qualifier.sv =====
// ----------------------------------------------------------------------------
// touch_button_event_qualifier
// Turns poll ticks (button level, touch sensor mask, raw position) into
// button, touch down/move/up, controller reset and idle timeout events.
// ----------------------------------------------------------------------------
//  channel   direction  handshake               payload
//  s_*       in         s_tvalid / s_tready     tick: tdata
//  m_*       out        m_tvalid / m_tready     event: tdata, tuser, tlast
//  cfg_*     in         cfg_valid / cfg_ready   cfg_index, cfg_data
//
//  a tick is registered, evaluated combinationally into up to three events and
//  replayed one event per cycle while m_tready is high; events are offered from
//  the event register, which holds them until the last is taken, so the tick rate
//  is one per cycle for ticks with at most one event while m_tready is high
//  the input register takes the next tick while events still wait on m_tready
//  synchronous reset restores register defaults and clears all qualifier state;
//  s_tready and cfg_ready stay low while reset is asserted
// ----------------------------------------------------------------------------
module touch_button_event_qualifier #(
    parameter int SENSOR_COUNT = 9
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // [0] button_pressed, [1] read_ok, [10:2] sensor_mask,
    // [18:11] raw_x, [26:19] raw_y, [31:27] zero
    input  logic [tbeq_pkg::S_DATA_W-1:0]       s_tdata,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // [6:0] point_x, [13:7] point_y, [15:14] zero
    output logic [tbeq_pkg::M_DATA_W-1:0]       m_tdata,
    // [2:0] event_kind, [3] controller_reset
    output logic [tbeq_pkg::M_USER_W-1:0]       m_tuser,
    output logic                                m_tlast,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [tbeq_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [tbeq_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import tbeq_pkg::*;

    cfg_t    cfg_reg;
    logic    in_valid_reg;
    tick_t   in_tick_reg;
    logic    out_valid_reg;
    result_t [MAX_RESULTS-1:0] out_items_reg;
    logic [1:0] out_count_reg;
    logic [1:0] out_idx_reg;
    bundle_t bundle;
    result_t cur_item;
    logic    out_final;
    logic    bundle_free;
    logic    step;

    // configuration
    assign cfg_ready = aresetn;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.touch_enabled     <= 1'b1;
            cfg_reg.sensor_lock_limit <= RST_SENSOR_LOCK_LIMIT;
            cfg_reg.idle_limit        <= RST_IDLE_LIMIT;
            cfg_reg.move_threshold    <= RST_MOVE_THRESHOLD;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_TOUCH_ENABLED:     cfg_reg.touch_enabled     <= cfg_data[0];
                CFG_SENSOR_LOCK_LIMIT: cfg_reg.sensor_lock_limit <= cfg_data[LOCK_W-1:0];
                CFG_IDLE_LIMIT:        cfg_reg.idle_limit        <= cfg_data[IDLE_W-1:0];
                CFG_MOVE_THRESHOLD:    cfg_reg.move_threshold    <= cfg_data[POINT_W-1:0];
                default: ;
            endcase
        end
    end

    // input register
    assign cur_item    = out_items_reg[out_idx_reg];
    assign out_final   = (out_idx_reg == out_count_reg - 2'd1);
    assign bundle_free = !out_valid_reg || (m_tready && out_final);
    assign step        = in_valid_reg && bundle_free;
    assign s_tready    = aresetn && (!in_valid_reg || step);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_tick_reg.button_pressed <= s_tdata[0];
            in_tick_reg.read_ok        <= s_tdata[1];
            in_tick_reg.sensor_mask    <= s_tdata[10:2];
            in_tick_reg.raw_x          <= s_tdata[18:11];
            in_tick_reg.raw_y          <= s_tdata[26:19];
        end
    end

    tbeq_core #(
        .SENSOR_COUNT(SENSOR_COUNT)
    ) u_core (
        .aclk   (aclk),
        .aresetn(aresetn),
        .cfg    (cfg_reg),
        .tick   (in_tick_reg),
        .step   (step),
        .bundle (bundle)
    );

    // event register and replay
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            out_count_reg <= '0;
            out_idx_reg   <= '0;
        end else if (step) begin
            out_valid_reg <= (bundle.count != 2'd0);
            out_count_reg <= bundle.count;
            out_idx_reg   <= '0;
        end else if (out_valid_reg && m_tready) begin
            if (out_final) begin
                out_valid_reg <= 1'b0;
            end else begin
                out_idx_reg <= out_idx_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            out_items_reg <= bundle.items;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_final;
    assign m_tdata  = {2'b00, cur_item.point_y, cur_item.point_x};
    assign m_tuser  = {cur_item.controller_reset, cur_item.kind};

endmodule

// ===== sv/tbeq_checker.sv =====
// ----------------------------------------------------------------------------
// tbeq_checker
// Port-level checks for the touch and button event qualifier.
// ----------------------------------------------------------------------------
module tbeq_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic [tbeq_pkg::M_DATA_W-1:0]   m_tdata,
    input logic [tbeq_pkg::M_USER_W-1:0]   m_tuser,
    input logic                            m_tlast,
    input logic                            m_tvalid,
    input logic                            m_tready
);
    import tbeq_pkg::*;

    // stalled transaction holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
            && $stable(m_tlast))
        else $error("event transaction changed while stalled");

    // no transaction right after reset
    a_reset_quiet: assert property (@(posedge aclk)
        $past(!aresetn) |-> !m_tvalid)
        else $error("event valid right after reset");

    // button and timeout events carry no point
    a_no_point: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser[2:0] == EV_BUTTON || m_tuser[2:0] == EV_TIMEOUT)
            |-> m_tdata == '0)
        else $error("point on non-touch event");

    // controller reset only rides on an up event
    a_reset_is_up: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[3] |-> m_tuser[2:0] == EV_UP)
        else $error("controller reset on wrong event kind");

    // timeout is always the final event of its tick
    a_timeout_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[2:0] == EV_TIMEOUT |-> m_tlast)
        else $error("timeout event not last");

endmodule

bind touch_button_event_qualifier tbeq_checker u_tbeq_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser),
    .m_tlast (m_tlast),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready)
);
